@@ rtl/pal_pkg.sv @@
// Shared constants, codes and types for the positional array list unit.
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

   localparam int CAPACITY_DEF = 64;

   localparam int MODE_W   = 2;
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 7;

   localparam logic [MODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] OP_DELETE = 2'd1;
   localparam logic [MODE_W-1:0] OP_GET    = 2'd2;
   localparam logic [MODE_W-1:0] OP_CLEAR  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic ins_en;
      logic del_en;
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ rtl/positional_array_list_unit.sv @@
// Top level of the positional array list unit: control, count and a chain of list cells.
//
//   channel   direction  handshake              payload
//   request   in         start & !busy          req_mode, req_position, req_value
//   response  out        rsp_strobe (1 cycle)   rsp_status, rsp_data, rsp_entry_total,
//                                               rsp_is_empty
//
// All cells shift in parallel at the accepting edge. The response appears the
// cycle after the item is accepted; busy stays low, so an item may be issued in
// every cycle. Reset empties the list (entry count to zero); cell contents are not
// cleared. The receiver cannot stall the response.
`timescale 1ns / 1ps
`default_nettype none

module positional_array_list_unit #(
   parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic        [pal_pkg::MODE_W-1:0]   req_mode,
   input  wire logic        [pal_pkg::POS_W-1:0]    req_position,
   input  wire logic signed [pal_pkg::DATA_W-1:0]   req_value,
   output logic                                    rsp_strobe,
   output logic             [pal_pkg::STATUS_W-1:0] rsp_status,
   output logic signed      [pal_pkg::DATA_W-1:0]   rsp_data,
   output logic             [pal_pkg::TOTAL_W-1:0]  rsp_entry_total,
   output logic                                    rsp_is_empty
);
   import pal_pkg::*;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W  = ($clog2(CAPACITY) > POS_W) ? $clog2(CAPACITY) : POS_W;
   localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [CMP_W-1:0]    cnt_ext;
   logic [CMP_W-1:0]    pos_ext;
   logic [CMP_W-1:0]    cnt_next_ext;
   logic                pos_ok_ins;
   logic                pos_ok_rd;
   logic                full;
   logic                accept;
   cell_ctl_type        ctl;
   logic [IDX_W-1:0]    ptr;

   logic [DATA_W-1:0]   cell_value [CAPACITY];
   logic [DATA_W-1:0]   cell_tap   [CAPACITY];
   logic [DATA_W-1:0]   tap_or;

   logic [STATUS_W-1:0] status_in;
   logic [DATA_W-1:0]   data_in;

   logic                strobe_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [DATA_W-1:0]   data_ff;
   logic [TOTAL_W-1:0]  total_ff;
   logic                empty_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign cnt_ext    = CMP_W'(count_ff);
   assign pos_ext    = CMP_W'(req_position);
   assign pos_ok_ins = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
   assign pos_ok_rd  = (pos_ext != '0) && (pos_ext <= cnt_ext);
   assign full       = (cnt_ext == CMP_W'(CAPACITY));
   assign ptr        = IDX_W'(req_position) - IDX_W'(1);

   assign ctl.ins_en = accept && (req_mode == OP_INSERT) && pos_ok_ins && !full;
   assign ctl.del_en = accept && (req_mode == OP_DELETE) && pos_ok_rd;

   genvar k;
   generate
      for (k = 0; k < CAPACITY; k++) begin : g_cell
         pal_cell #(
            .INDEX    (k),
            .IDX_W    (IDX_W)
         ) u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .ptr         (ptr),
            .ins_value   (req_value),
            .left_value  (cell_value[(k == 0) ? 0 : k - 1]),
            .right_value (cell_value[(k == CAPACITY - 1) ? k : k + 1]),
            .value       (cell_value[k]),
            .tap         (cell_tap[k])
         );
      end
   endgenerate

   always_comb begin
      tap_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tap_or = tap_or | cell_tap[i];
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = ST_OK;
      data_in   = '0;
      unique case (req_mode)
         OP_INSERT: begin
            if (!pos_ok_ins) begin
               status_in = ST_RANGE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_DELETE: begin
            if (!pos_ok_rd) begin
               status_in = ST_RANGE;
            end else begin
               data_in  = tap_or;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_GET: begin
            if (!pos_ok_rd) begin
               status_in = ST_RANGE;
            end else begin
               data_in = tap_or;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   assign cnt_next_ext = CMP_W'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         data_ff   <= data_in;
         total_ff  <= cnt_next_ext[TOTAL_W-1:0];
         empty_ff  <= (count_in == '0);
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_data        = data_ff;
   assign rsp_entry_total = total_ff;
   assign rsp_is_empty    = empty_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(CAPACITY))
      else $error("entry count above capacity");

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      start |=> rsp_strobe)
      else $error("accepted item gave no response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !start |=> !rsp_strobe)
      else $error("response without an item");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      start && (req_mode == OP_CLEAR) |=> rsp_is_empty && (rsp_status == ST_OK))
      else $error("clear left entries");

   a_err_data: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != ST_OK) |-> (rsp_data == '0))
      else $error("error response carries data");
`endif

endmodule

`default_nettype wire

@@ rtl/pal_cell.sv @@
// One list cell: holds an entry and shifts with its neighbors on insert and delete.
`timescale 1ns / 1ps
`default_nettype none

module pal_cell #(
   parameter int INDEX    = 0,
   parameter int IDX_W    = pal_pkg::POS_W
) (
   input  wire logic                        clock,
   input  wire pal_pkg::cell_ctl_type       ctl,
   input  wire logic [IDX_W-1:0]            ptr,
   input  wire logic [pal_pkg::DATA_W-1:0]  ins_value,
   input  wire logic [pal_pkg::DATA_W-1:0]  left_value,
   input  wire logic [pal_pkg::DATA_W-1:0]  right_value,
   output logic      [pal_pkg::DATA_W-1:0]  value,
   output logic      [pal_pkg::DATA_W-1:0]  tap
);
   import pal_pkg::*;

   localparam logic [IDX_W-1:0] ME = IDX_W'(INDEX);

   logic [DATA_W-1:0] cell_ff;
   logic [DATA_W-1:0] cell_in;
   logic              at_ptr;
   logic              above_ptr;

   assign at_ptr    = (ptr == ME);
   assign above_ptr = (ME > ptr);

   always_comb begin
      cell_in = cell_ff;
      if (ctl.ins_en) begin
         if (at_ptr) begin
            cell_in = ins_value;
         end else if (above_ptr) begin
            cell_in = left_value;
         end
      end else if (ctl.del_en) begin
         if (at_ptr || above_ptr) begin
            cell_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign value = cell_ff;
   assign tap   = at_ptr ? cell_ff : '0;

endmodule

`default_nettype wire
